### hdl/rcfp_pkg.sv
// rcfp_pkg: shared constants for the resp command frame parser
// result kinds, error codes, protocol characters and limits; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcfp_pkg;

  localparam int unsigned ACC_W     = 25;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned LEN_W     = 24;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [CNT_W-1:0] MAX_ARGS     = 11'd1024;
  localparam logic [LEN_W-1:0] MAX_BULK_LEN = 24'd16777215;
  localparam logic [ACC_W-1:0] ACC_SAT      = 25'h1FFFFFF;

  localparam logic [CNT_W-1:0] ARG_LIMIT_RST = 11'd1024;
  localparam logic [LEN_W-1:0] LEN_LIMIT_RST = 24'd16777215;

  // configuration register indexes
  localparam logic CFG_ARG_COUNT_LIMIT   = 1'b0;
  localparam logic CFG_BULK_LENGTH_LIMIT = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [CODE_W-1:0] ERR_NO_STAR    = 3'd0;
  localparam logic [CODE_W-1:0] ERR_BAD_COUNT  = 3'd1;
  localparam logic [CODE_W-1:0] ERR_NO_DOLLAR  = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BAD_LENGTH = 3'd3;
  localparam logic [CODE_W-1:0] ERR_NO_TRAILER = 3'd4;

  // protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

endpackage : rcfp_pkg

`default_nettype wire

### hdl/resp_command_frame_parser_top.sv
// resp_command_frame_parser_top: byte-wise parser for array-of-bulk-string commands
// single module with one output register; depends on rcfp_pkg
//
// usage:
//   in_*  : one request byte per transaction (in_tdata[7:0])
//   out_* : zero or one result per byte; out_tuser is the kind (payload byte,
//           argument end, protocol error), out_tlast flags the argument end
//           that completes a command, out_tdata carries the other fields
//   cfg_* : write-only limits, written while the block is idle
// latency: a result appears on out_* in the cycle after its byte is taken
// throughput: one byte per cycle while no result is stalled; the whole parse
//   step for a byte is one pass through the phase logic and the x10 digit
//   adder into the result register
// header bytes and framing characters give no result
// stall: while a result waits with out_tready low, in_tready is low; as soon
//   as the result is taken the next byte is accepted in the same cycle
// reset (rst_n low, synchronous): phase returns to expecting '*', counters
//   clear, limits go to 1024 arguments and 16777215 bytes, the error latch
//   clears and the output register empties
// a protocol error is latched; every later byte returns an error result
//   with the same code until reset
`timescale 1ns / 1ps
`default_nettype none

module resp_command_frame_parser_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] stream_byte
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] payload_byte, [17:8] arg_position, [41:18] arg_length,
  // [52:42] command_args, [55:53] error_code
  output logic [rcfp_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [rcfp_pkg::KIND_W-1:0]           out_tuser,  // [1:0] kind
  output logic                                  out_tlast,  // command_done
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [rcfp_pkg::LEN_W-1:0]       cfg_wdata
);
  import rcfp_pkg::*;

  localparam logic [3:0] PH_STAR      = 4'd0;
  localparam logic [3:0] PH_CNT_FIRST = 4'd1;
  localparam logic [3:0] PH_CNT_MORE  = 4'd2;
  localparam logic [3:0] PH_CNT_LF    = 4'd3;
  localparam logic [3:0] PH_DOLLAR    = 4'd4;
  localparam logic [3:0] PH_LEN       = 4'd5;
  localparam logic [3:0] PH_LEN_LF    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD   = 4'd7;
  localparam logic [3:0] PH_TAIL_CR   = 4'd8;
  localparam logic [3:0] PH_TAIL_LF   = 4'd9;
  localparam logic [3:0] PH_ERROR     = 4'd10;

  // configuration
  logic [CNT_W-1:0] arg_limit_r;
  logic [LEN_W-1:0] len_limit_r;

  // parse state
  logic [3:0]       phase_r, phase_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] count_total_r, count_total_nxt;
  logic [CNT_W-1:0] args_left_r, args_left_nxt;
  logic [POS_W-1:0] arg_counter_r, arg_counter_nxt;
  logic [LEN_W-1:0] payload_left_r, payload_left_nxt;
  logic [LEN_W-1:0] payload_total_r, payload_total_nxt;
  logic [CODE_W-1:0] err_code_r, err_code_nxt;

  // result register
  logic                  out_valid_r;
  logic [KIND_W-1:0]     res_kind_r, res_kind;
  logic [OUT_DATA_W-1:0] res_data_r, res_data;
  logic                  res_last_r;
  logic                  res_valid;

  // combinational helpers
  logic             in_accept;
  logic [7:0]       b;
  logic             is_digit;
  logic [3:0]       digit;
  logic [28:0]      acc_x10;
  logic [ACC_W-1:0] acc_step;
  logic [CNT_W-1:0] cnt_lim;
  logic [LEN_W-1:0] len_lim;
  logic [7:0]       res_byte;
  logic [LEN_W-1:0] res_len;
  logic             res_done;
  logic [CODE_W-1:0] res_code;
  logic             fail;
  logic [CODE_W-1:0] fail_code;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_accept = in_tvalid & in_tready;
  assign b         = in_tdata;

  assign is_digit = (b inside {[CH_ZERO:CH_NINE]});
  assign digit    = 4'(b - CH_ZERO);
  // acc * 10 + digit, saturating
  assign acc_x10  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {25'b0, digit};
  assign acc_step = (acc_x10 > {4'b0, ACC_SAT}) ? ACC_SAT : acc_x10[ACC_W-1:0];

  assign cnt_lim = (arg_limit_r < MAX_ARGS) ? arg_limit_r : MAX_ARGS;
  assign len_lim = (len_limit_r < MAX_BULK_LEN) ? len_limit_r : MAX_BULK_LEN;

  always_comb begin
    phase_nxt         = phase_r;
    acc_nxt           = acc_r;
    count_total_nxt   = count_total_r;
    args_left_nxt     = args_left_r;
    arg_counter_nxt   = arg_counter_r;
    payload_left_nxt  = payload_left_r;
    payload_total_nxt = payload_total_r;
    err_code_nxt      = err_code_r;
    res_valid         = 1'b0;
    res_kind          = KIND_PAYLOAD;
    res_byte          = 8'd0;
    res_len           = '0;
    res_done          = 1'b0;
    res_code          = '0;
    fail              = 1'b0;
    fail_code         = err_code_r;

    case (phase_r)
      PH_STAR: begin
        if (b != CH_STAR) begin
          fail      = 1'b1;
          fail_code = ERR_NO_STAR;
        end else begin
          count_total_nxt = '0;
          arg_counter_nxt = '0;
          acc_nxt         = '0;
          phase_nxt       = PH_CNT_FIRST;
        end
      end
      PH_CNT_FIRST, PH_CNT_MORE: begin
        if (is_digit) begin
          acc_nxt   = acc_step;
          phase_nxt = PH_CNT_MORE;
        end else if (b == CH_CR && phase_r == PH_CNT_MORE && acc_r != '0 &&
                     acc_r <= {14'b0, cnt_lim}) begin
          phase_nxt = PH_CNT_LF;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_BAD_COUNT;
        end
      end
      PH_CNT_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_COUNT;
        end else begin
          // count already checked against the limit, so it fits
          count_total_nxt = acc_r[CNT_W-1:0];
          args_left_nxt   = acc_r[CNT_W-1:0];
          arg_counter_nxt = '0;
          phase_nxt       = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          fail      = 1'b1;
          fail_code = ERR_NO_DOLLAR;
        end else begin
          acc_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          acc_nxt = acc_step;
        end else if (b == CH_CR && acc_r <= {1'b0, len_lim}) begin
          phase_nxt = PH_LEN_LF;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_BAD_LENGTH;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_LENGTH;
        end else begin
          payload_total_nxt = acc_r[LEN_W-1:0];
          payload_left_nxt  = acc_r[LEN_W-1:0];
          phase_nxt = (acc_r == '0) ? PH_TAIL_CR : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res_kind         = KIND_PAYLOAD;
        res_byte         = b;
        payload_left_nxt = payload_left_r - 24'd1;
        if (payload_left_r == 24'd1) begin
          phase_nxt = PH_TAIL_CR;
        end
      end
      PH_TAIL_CR: begin
        if (b != CH_CR) begin
          fail      = 1'b1;
          fail_code = ERR_NO_TRAILER;
        end else begin
          phase_nxt = PH_TAIL_LF;
        end
      end
      PH_TAIL_LF: begin
        if (b != CH_LF) begin
          fail      = 1'b1;
          fail_code = ERR_NO_TRAILER;
        end else begin
          res_valid = 1'b1;
          res_kind  = KIND_ARG_END;
          res_len   = payload_total_r;
          res_done  = (args_left_r <= 11'd1);
          if (res_done) begin
            args_left_nxt   = '0;
            arg_counter_nxt = '0;
            count_total_nxt = '0;
            phase_nxt       = PH_STAR;
          end else begin
            args_left_nxt   = args_left_r - 11'd1;
            arg_counter_nxt = arg_counter_r + 10'd1;
            phase_nxt       = PH_DOLLAR;
          end
        end
      end
      default: begin
        // sticky error: repeat the latched code
        fail      = 1'b1;
        fail_code = err_code_r;
      end
    endcase

    if (fail) begin
      phase_nxt    = PH_ERROR;
      err_code_nxt = fail_code;
      res_valid    = 1'b1;
      res_kind     = KIND_ERROR;
      res_code     = fail_code;
    end
  end

  // fields come from the state before this byte's update
  assign res_data = {res_code, count_total_r, res_len, arg_counter_r, res_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_limit_r <= ARG_LIMIT_RST;
      len_limit_r <= LEN_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ARG_COUNT_LIMIT) begin
        arg_limit_r <= cfg_wdata[CNT_W-1:0];
      end else begin
        len_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_STAR;
      acc_r           <= '0;
      count_total_r   <= '0;
      args_left_r     <= '0;
      arg_counter_r   <= '0;
      payload_left_r  <= '0;
      payload_total_r <= '0;
      err_code_r      <= '0;
    end else if (in_accept) begin
      phase_r         <= phase_nxt;
      acc_r           <= acc_nxt;
      count_total_r   <= count_total_nxt;
      args_left_r     <= args_left_nxt;
      arg_counter_r   <= arg_counter_nxt;
      payload_left_r  <= payload_left_nxt;
      payload_total_r <= payload_total_nxt;
      err_code_r      <= err_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_accept & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      res_kind_r <= res_kind;
      res_data_r <= res_data;
      res_last_r <= res_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_data_r;
  assign out_tuser  = res_kind_r;
  assign out_tlast  = res_last_r;

  // error latch never clears outside reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("parser left the error phase without reset");

  // a payload phase always has bytes left to take
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> payload_left_r != '0)
    else $error("payload phase with zero bytes left");

  // only error transactions carry a nonzero code
  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_kind_r != KIND_ERROR) |-> res_data_r[55:53] == '0)
    else $error("error code on a non-error transaction");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

endmodule : resp_command_frame_parser_top

`default_nettype wire
